/* rtl/cmmd_pkg.sv */
// shared types and constants for the centered moving mean detrend block
`default_nettype none

package cmmd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_W     = 4;
  localparam int unsigned DET_W      = 21;
  // width of the biased mean quotient
  localparam int unsigned Q_W        = 21;
  // register stages in a lane, from the line read registers to the detrended result
  localparam int unsigned LANE_DEPTH = 5;

  // bias that keeps the mean quotient non-negative
  localparam logic [DET_W-1:0] Q_BIAS = DET_W'(1) << (SAMPLE_W + FRAC_W);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DET_W-1:0]    det_t;

  // first pipeline stage after the delay line
  typedef struct packed {
    logic valid;
    logic first;
    logic sub;
    logic emit;
  } cmmd_s1_t;

  // lane control
  typedef struct packed {
    logic en;
    logic acc;
    logic first;
    logic sub;
  } cmmd_ctl_t;

endpackage

`default_nettype wire

/* rtl/cmmd_if.sv */
// valid/ready channel interfaces for sample pairs and detrended results
`default_nettype none

interface cmmd_in_if import cmmd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    first;
  sample_t sample_a;
  sample_t sample_b;

  modport source (output valid, output first, output sample_a, output sample_b, input ready);
  modport sink (input valid, input first, input sample_a, input sample_b, output ready);
endinterface

interface cmmd_out_if import cmmd_pkg::*; ();
  logic valid;
  logic ready;
  det_t detrended_a;
  det_t detrended_b;

  modport source (output valid, output detrended_a, output detrended_b, input ready);
  modport sink (input valid, input detrended_a, input detrended_b, output ready);
endinterface

`default_nettype wire

/* rtl/cmmd_line.sv */
// sample delay line with write and centre pointers, fill count and first stage registers
`default_nettype none

module cmmd_line import cmmd_pkg::*; #(
  parameter int HALF_WINDOW = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire logic     accept,
  input  wire logic     first,
  input  wire sample_t  sample_a,
  input  wire sample_t  sample_b,
  output cmmd_s1_t      s1,
  output sample_t       s1_a,
  output sample_t       s1_b,
  output sample_t       old_a,
  output sample_t       old_b,
  output sample_t       cen_a,
  output sample_t       cen_b
);

  localparam int WIN    = 2 * HALF_WINDOW + 1;
  localparam int SLOT_W = $clog2(WIN);
  localparam int FILL_W = $clog2(WIN + 1);
  localparam logic [FILL_W-1:0] WIN_F   = FILL_W'(WIN);
  localparam logic [SLOT_W-1:0] LAST_SL = SLOT_W'(WIN - 1);
  localparam logic [SLOT_W-1:0] CTR_RST = SLOT_W'(HALF_WINDOW + 1);

  logic [2*SAMPLE_W-1:0] line_mem [WIN];

  logic [SLOT_W-1:0]     wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0]     ctr_slot_r, ctr_slot_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt, fill_base;
  logic                  sub_c, emit_c;
  cmmd_s1_t              s1_r;
  logic [2*SAMPLE_W-1:0] old_r, cen_r, samp_r;

  always_comb begin
    fill_base    = first ? '0 : fill_r;
    sub_c        = (fill_base == WIN_F);
    fill_nxt     = sub_c ? fill_base : fill_base + 1'b1;
    emit_c       = (fill_nxt == WIN_F);
    wr_slot_nxt  = (wr_slot_r == LAST_SL) ? '0 : wr_slot_r + 1'b1;
    ctr_slot_nxt = (ctr_slot_r == LAST_SL) ? '0 : ctr_slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r  <= '0;
      ctr_slot_r <= CTR_RST;
      fill_r     <= '0;
      s1_r       <= '0;
    end else begin
      if (accept) begin
        wr_slot_r  <= wr_slot_nxt;
        ctr_slot_r <= ctr_slot_nxt;
        fill_r     <= fill_nxt;
      end
      if (adv) begin
        s1_r.valid <= accept;
        s1_r.first <= first;
        s1_r.sub   <= sub_c;
        s1_r.emit  <= accept && emit_c;
      end
    end
  end

  // read-first: the oldest pair leaves as the new one takes its slot
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[wr_slot_r] <= {sample_b, sample_a};
    end
    if (adv) begin
      old_r  <= line_mem[wr_slot_r];
      cen_r  <= line_mem[ctr_slot_r];
      samp_r <= {sample_b, sample_a};
    end
  end

  assign s1    = s1_r;
  assign s1_a  = samp_r[SAMPLE_W-1:0];
  assign s1_b  = samp_r[2*SAMPLE_W-1:SAMPLE_W];
  assign old_a = old_r[SAMPLE_W-1:0];
  assign old_b = old_r[2*SAMPLE_W-1:SAMPLE_W];
  assign cen_a = cen_r[SAMPLE_W-1:0];
  assign cen_b = cen_r[2*SAMPLE_W-1:SAMPLE_W];

endmodule

`default_nettype wire

/* rtl/cmmd_lane.sv */
// one channel lane: running sum, rounded mean by reciprocal multiply, centre minus mean
`default_nettype none

module cmmd_lane import cmmd_pkg::*; #(
  parameter int HALF_WINDOW = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmmd_ctl_t ctl,
  input  wire sample_t   sample,
  input  wire sample_t   old,
  input  wire sample_t   centre,
  output det_t           detrended
);

  localparam int WIN    = 2 * HALF_WINDOW + 1;
  localparam int DEN    = 2 * WIN;
  localparam int SUM_W  = $clog2(WIN) + SAMPLE_W;
  localparam int NU_W   = $clog2(WIN) + SAMPLE_W + FRAC_W + 2;
  localparam int M_W    = NU_W - $clog2(DEN) + 2;
  localparam int PROD_W = NU_W + M_W;

  localparam logic [63:0]     RECIP64 = (64'd1 << NU_W) / 64'(DEN);
  localparam logic [M_W-1:0]  RECIP   = RECIP64[M_W-1:0];
  localparam logic [NU_W-1:0] DEN_NU  = NU_W'(DEN);
  // rounding half-step plus a bias that keeps the numerator positive
  localparam logic [NU_W-1:0] OFS =
    NU_W'(64'(WIN) + (64'(DEN) << (SAMPLE_W + FRAC_W)));

  logic signed [SUM_W-1:0] sum_r, sum_base, sum_nxt;
  logic [NU_W-1:0]         sum_ext, num_u, rem;
  logic [PROD_W-1:0]       prod_r;
  logic [NU_W-1:0]         num3_r, num4_r, qd_r;
  logic [Q_W-1:0]          q0, q0_r, q_r;
  sample_t                 cen2_r, cen3_r, cen4_r, cen5_r;
  logic [DET_W-1:0]        cen_ext, det_r;

  always_comb begin
    sum_base = ctl.first ? '0 : sum_r;
    sum_nxt  = sum_base + SUM_W'(sample) - (ctl.sub ? SUM_W'(old) : '0);
    sum_ext  = NU_W'(sum_r);
    num_u    = (sum_ext << (FRAC_W + 1)) + OFS;
    q0       = prod_r[NU_W +: Q_W];
    rem      = num4_r - qd_r;
    cen_ext  = {{(DET_W - SAMPLE_W - FRAC_W){cen5_r[SAMPLE_W-1]}}, cen5_r, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      cen2_r <= centre;
      prod_r <= {{M_W{1'b0}}, num_u} * {{NU_W{1'b0}}, RECIP};
      num3_r <= num_u;
      cen3_r <= cen2_r;
      // estimate is exact or one low
      q0_r   <= q0;
      qd_r   <= {{(NU_W - Q_W){1'b0}}, q0} * DEN_NU;
      num4_r <= num3_r;
      cen4_r <= cen3_r;
      q_r    <= q0_r + Q_W'(rem >= DEN_NU);
      cen5_r <= cen4_r;
      det_r  <= cen_ext + Q_BIAS - DET_W'(q_r);
    end
  end

  assign detrended = det_r;

endmodule

`default_nettype wire

/* rtl/cmmd_merge.sv */
// joins the lane results into one beat, output register with one skid entry
`default_nettype none

module cmmd_merge import cmmd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire det_t     det_a,
  input  wire det_t     det_b,
  output logic          adv,
  cmmd_out_if.source    out_ch
);

  logic out_valid_r, skid_full_r, take;
  det_t out_a_r, out_b_r, skid_a_r, skid_b_r;

  assign take = out_valid_r && out_ch.ready;
  assign adv  = !skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (take) begin
        skid_full_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_a_r <= skid_a_r;
        out_b_r <= skid_b_r;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_a_r <= det_a;
        out_b_r <= det_b;
      end else begin
        skid_a_r <= det_a;
        skid_b_r <= det_b;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.detrended_a = out_a_r;
  assign out_ch.detrended_b = out_b_r;

endmodule

`default_nettype wire

/* rtl/centered_moving_mean_detrend_top.sv */
// Centered moving mean detrend, two sensor channels.
// in_ch carries one sample pair per beat plus a first flag that starts a new
// record; out_ch carries, per beat, centre sample minus window mean for both
// channels, with 4 fraction bits. The window holds 2*HALF_WINDOW+1 pairs; the
// first 2*HALF_WINDOW beats of a record give no result, every later beat
// gives one, for the pair taken HALF_WINDOW beats earlier.
// Throughput is one beat per cycle while out_ch takes results: the delay line
// memory is written and read at both the oldest and the centre slot in the
// same cycle, and each channel lane runs a five stage pipeline (running sum,
// reciprocal multiply, remainder check, quotient fix, subtract). A result
// passes the first stage registers, the lane stages and the output register.
// Reset clears the pointers, the fill count, the sums and the valid flags; the
// delay line memory and lane data are not cleared and need no clearing pass.
// When the receiver stalls, one result waits in the output register and one
// more in a skid entry; then in_ch.ready drops and the whole pipeline holds.
`default_nettype none

module centered_moving_mean_detrend_top import cmmd_pkg::*; #(
  parameter int HALF_WINDOW = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cmmd_in_if.sink    in_ch,
  cmmd_out_if.source out_ch
);

  logic                  adv, accept, push;
  cmmd_s1_t              s1;
  cmmd_ctl_t             ctl;
  sample_t               s1_a, s1_b, old_a, old_b, cen_a, cen_b;
  det_t                  det_a, det_b;
  logic [LANE_DEPTH-1:0] emit_pipe_r;

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;

  cmmd_line #(.HALF_WINDOW(HALF_WINDOW)) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (accept),
    .first    (in_ch.first),
    .sample_a (in_ch.sample_a),
    .sample_b (in_ch.sample_b),
    .s1       (s1),
    .s1_a     (s1_a),
    .s1_b     (s1_b),
    .old_a    (old_a),
    .old_b    (old_b),
    .cen_a    (cen_a),
    .cen_b    (cen_b)
  );

  always_comb begin
    ctl.en    = adv;
    ctl.acc   = adv && s1.valid;
    ctl.first = s1.first;
    ctl.sub   = s1.sub;
  end

  cmmd_lane #(.HALF_WINDOW(HALF_WINDOW)) u_lane_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (s1_a),
    .old       (old_a),
    .centre    (cen_a),
    .detrended (det_a)
  );

  cmmd_lane #(.HALF_WINDOW(HALF_WINDOW)) u_lane_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (s1_b),
    .old       (old_b),
    .centre    (cen_b),
    .detrended (det_b)
  );

  // tracks which beats in the lanes produce a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_pipe_r <= '0;
    end else if (adv) begin
      emit_pipe_r <= {emit_pipe_r[LANE_DEPTH-2:0], s1.emit};
    end
  end

  assign push = adv && emit_pipe_r[LANE_DEPTH-1];

  cmmd_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .det_a  (det_a),
    .det_b  (det_b),
    .adv    (adv),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result pending");

  a_first_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.first) |=> !s1.emit)
    else $error("new record marked for a result on its first beat");

  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(push))
    else $error("result appeared without a lane push");
`endif

endmodule

`default_nettype wire
